@@ src/uemr_pkg.sv @@
package uemr_pkg;

    localparam int MEDIAN_SIZE = 5;
    localparam int HIST_DEPTH  = MEDIAN_SIZE - 1;
    localparam int MID_IDX     = MEDIAN_SIZE / 2;
    localparam int POS_W       = $clog2(HIST_DEPTH);
    localparam int PULSE_W     = 16;
    localparam int DIST_W      = 20;
    localparam int NUM_W       = 22;
    localparam int REM_W       = PULSE_W + 1;
    localparam int CNT_W       = $clog2(NUM_W);

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic        req_type;
        logic        echo_level;
        logic [31:0] timer_count;
    } in_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_cm;
        logic              trigger_request;
        logic              echo_led;
        logic              forced_update;
        logic              sample_rejected;
    } out_t;

    typedef struct packed {
        logic [15:0] ticks_per_ms;
        logic [15:0] pulse_limit;
        logic [7:0]  watchdog_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_MED,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic sort_step;
        logic sort_par;
        logic med_load;
        logic div_step;
        logic out_load;
    } cmd_t;

endpackage

@@ src/uemr_ctrl.sv @@
module uemr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output uemr_pkg::cmd_t    cmd
);

    uemr_pkg::state_t             state_reg, state_next;
    logic [uemr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= uemr_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.sort_par = cnt_reg[0];
        unique case (state_reg)
            uemr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = uemr_pkg::ST_SORT;
                end
            end
            uemr_pkg::ST_SORT: begin
                cmd.sort_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == uemr_pkg::CNT_W'(uemr_pkg::MEDIAN_SIZE - 1)) begin
                    state_next = uemr_pkg::ST_MED;
                end
            end
            uemr_pkg::ST_MED: begin
                cmd.med_load = 1'b1;
                cnt_next     = '0;
                state_next   = uemr_pkg::ST_DIV;
            end
            uemr_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == uemr_pkg::CNT_W'(uemr_pkg::NUM_W - 1)) begin
                    state_next = uemr_pkg::ST_DONE;
                end
            end
            uemr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = uemr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = uemr_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == uemr_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

    a_accept_to_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == uemr_pkg::ST_SORT)
        else $error("accepted beat did not start the sort");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == uemr_pkg::ST_DIV && cnt_reg == uemr_pkg::CNT_W'(uemr_pkg::NUM_W - 1))
        |=> state_reg == uemr_pkg::ST_DONE)
        else $error("divider ran past its last step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while holding a beat");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

@@ src/uemr_dp.sv @@
module uemr_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  uemr_pkg::cmd_t    cmd,
    input  uemr_pkg::in_t     in_data,
    input  uemr_pkg::cfg_t    cfg,
    output uemr_pkg::out_t    out_data
);

    logic [31:0]                    echo_start_reg, echo_start_next;
    logic [uemr_pkg::PULSE_W-1:0]   last_pulse_reg, last_pulse_next;
    logic [uemr_pkg::PULSE_W-1:0]   hist_reg [uemr_pkg::HIST_DEPTH];
    logic [uemr_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [uemr_pkg::PULSE_W-1:0]   median_reg;
    logic                           echo_seen_reg, echo_seen_next;
    logic [7:0]                     idle_reg, idle_next;
    logic                           led_reg, led_next;

    logic                           upd_reg, forced_reg, rej_reg;
    logic                           upd, forced, rej;

    logic [uemr_pkg::PULSE_W-1:0]   sort_reg  [uemr_pkg::MEDIAN_SIZE];
    logic [uemr_pkg::PULSE_W-1:0]   sort_next [uemr_pkg::MEDIAN_SIZE];

    logic [uemr_pkg::NUM_W-1:0]     num_reg, quo_reg, num_init;
    logic [uemr_pkg::REM_W-1:0]     rem_reg, dvs;
    logic [uemr_pkg::REM_W:0]       trial, diff;
    logic [uemr_pkg::PULSE_W-1:0]   med_sel, dvd;
    logic [31:0]                    width;
    uemr_pkg::out_t                 out_reg;

    // item decode
    always_comb begin
        width           = in_data.timer_count - echo_start_reg;
        echo_start_next = echo_start_reg;
        last_pulse_next = last_pulse_reg;
        echo_seen_next  = echo_seen_reg;
        idle_next       = idle_reg;
        led_next        = led_reg;
        upd             = 1'b0;
        forced          = 1'b0;
        rej             = 1'b0;
        if (!in_data.req_type) begin
            if (in_data.echo_level) begin
                echo_start_next = in_data.timer_count;
                led_next        = 1'b1;
            end else begin
                led_next = 1'b0;
                upd      = 1'b1;
                if (width < {16'd0, cfg.pulse_limit}) begin
                    last_pulse_next = width[uemr_pkg::PULSE_W-1:0];
                end else begin
                    rej = 1'b1;
                end
            end
        end else begin
            priority if (echo_seen_reg) begin
                echo_seen_next = 1'b0;
                idle_next      = '0;
            end else if (idle_reg == cfg.watchdog_limit) begin
                idle_next = '0;
                upd       = 1'b1;
                forced    = 1'b1;
            end else begin
                idle_next = idle_reg + 8'd1;
            end
        end
        if (upd) begin
            echo_seen_next = 1'b1;
        end
        pos_next = (pos_reg == uemr_pkg::POS_W'(uemr_pkg::HIST_DEPTH - 1)) ? '0
                                                                          : pos_reg + 1'b1;
    end

    // one odd-even transposition pass
    always_comb begin
        for (int k = 0; k < uemr_pkg::MEDIAN_SIZE; k++) begin
            sort_next[k] = sort_reg[k];
        end
        for (int k = 0; k < uemr_pkg::MEDIAN_SIZE - 1; k++) begin
            if (((k % 2) == 1) == cmd.sort_par && sort_reg[k] > sort_reg[k+1]) begin
                sort_next[k]   = sort_reg[k+1];
                sort_next[k+1] = sort_reg[k];
            end
        end
    end

    // distance = (34*m + d) / (2*d), restoring division
    always_comb begin
        med_sel  = upd_reg ? sort_reg[uemr_pkg::MID_IDX] : median_reg;
        dvd      = (cfg.ticks_per_ms == 16'd0) ? 16'd1 : cfg.ticks_per_ms;
        dvs      = {dvd, 1'b0};
        num_init = {1'b0, med_sel, 5'b0} + {5'b0, med_sel, 1'b0} + {6'b0, dvd};
        trial    = {rem_reg, num_reg[uemr_pkg::NUM_W-1]};
        diff     = trial - {1'b0, dvs};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_start_reg <= '0;
            last_pulse_reg <= '0;
            pos_reg        <= '0;
            median_reg     <= '0;
            echo_seen_reg  <= 1'b0;
            idle_reg       <= '0;
            led_reg        <= 1'b0;
            for (int i = 0; i < uemr_pkg::HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            if (cmd.accept) begin
                echo_start_reg <= echo_start_next;
                last_pulse_reg <= last_pulse_next;
                echo_seen_reg  <= echo_seen_next;
                idle_reg       <= idle_next;
                led_reg        <= led_next;
                if (upd) begin
                    hist_reg[pos_reg] <= last_pulse_next;
                    pos_reg           <= pos_next;
                end
            end
            if (cmd.med_load) begin
                median_reg <= med_sel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            upd_reg    <= upd;
            forced_reg <= forced;
            rej_reg    <= rej;
            for (int i = 0; i < uemr_pkg::HIST_DEPTH; i++) begin
                sort_reg[i] <= hist_reg[i];
            end
            sort_reg[uemr_pkg::HIST_DEPTH] <= last_pulse_next;
        end else if (cmd.sort_step) begin
            for (int i = 0; i < uemr_pkg::MEDIAN_SIZE; i++) begin
                sort_reg[i] <= sort_next[i];
            end
        end
        if (cmd.med_load) begin
            num_reg <= num_init;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[uemr_pkg::NUM_W-2:0], 1'b0};
            if (!diff[uemr_pkg::REM_W]) begin
                rem_reg <= diff[uemr_pkg::REM_W-1:0];
                quo_reg <= {quo_reg[uemr_pkg::NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[uemr_pkg::REM_W-1:0];
                quo_reg <= {quo_reg[uemr_pkg::NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            out_reg.dist_cm         <= (quo_reg > uemr_pkg::NUM_W'(uemr_pkg::DIST_MAX))
                                       ? uemr_pkg::DIST_MAX
                                       : quo_reg[uemr_pkg::DIST_W-1:0];
            out_reg.trigger_request <= upd_reg;
            out_reg.echo_led        <= led_reg;
            out_reg.forced_update   <= forced_reg;
            out_reg.sample_rejected <= rej_reg;
        end
    end

    assign out_data = out_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= uemr_pkg::POS_W'(uemr_pkg::HIST_DEPTH - 1))
        else $error("history write index out of range");

endmodule

@@ src/ultrasonic_echo_median_ranger.sv @@
// Echo ranger: each input beat (echo edge or watchdog tick) yields exactly one result beat.
// A falling edge or a watchdog timeout refreshes the median of the last MEDIAN_SIZE pulse
// widths; every result carries round(17*median/ticks_per_ms) in cm, saturated to 20 bits.
// An item runs one odd-even sort pass per cycle over the sample window, then a 22-step
// serial divider for the distance; the next beat is accepted once the result has moved
// into the output register.
// Registers: 0x0 ticks_per_ms, 0x4 pulse_limit, 0x8 watchdog_limit.
module ultrasonic_echo_median_ranger (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  uemr_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output uemr_pkg::out_t    m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [1:0] REG_TICKS_PER_MS   = 2'd0;
    localparam logic [1:0] REG_PULSE_LIMIT    = 2'd1;
    localparam logic [1:0] REG_WATCHDOG_LIMIT = 2'd2;

    uemr_pkg::cfg_t cfg_reg;
    uemr_pkg::cmd_t cmd;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_ms   <= 16'd1000;
            cfg_reg.pulse_limit    <= 16'd32767;
            cfg_reg.watchdog_limit <= 8'd9;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_TICKS_PER_MS:   cfg_reg.ticks_per_ms   <= pwdata[15:0];
                REG_PULSE_LIMIT:    cfg_reg.pulse_limit    <= pwdata[15:0];
                REG_WATCHDOG_LIMIT: cfg_reg.watchdog_limit <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TICKS_PER_MS:   prdata = {16'd0, cfg_reg.ticks_per_ms};
            REG_PULSE_LIMIT:    prdata = {16'd0, cfg_reg.pulse_limit};
            REG_WATCHDOG_LIMIT: prdata = {24'd0, cfg_reg.watchdog_limit};
            default:            prdata = '0;
        endcase
    end

    uemr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    uemr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_data),
        .cfg      (cfg_reg),
        .out_data (m_data)
    );

endmodule

@@ test/uemr_tb_pkg.sv @@
`timescale 1ns / 100ps

package uemr_tb_pkg;

    typedef enum logic [3:0] {
        REG_TICKS_PER_MS   = 4'h0,
        REG_PULSE_LIMIT    = 4'h4,
        REG_WATCHDOG_LIMIT = 4'h8
    } reg_addr_t;

    typedef enum logic {
        REQ_ECHO     = 1'b0,
        REQ_WATCHDOG = 1'b1
    } req_kind_t;

    typedef enum logic {
        LEVEL_FALL = 1'b0,
        LEVEL_RISE = 1'b1
    } echo_edge_t;

endpackage

@@ test/uemr_checker.sv @@
`timescale 1ns / 100ps

module uemr_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  uemr_pkg::in_t     s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  uemr_pkg::out_t    m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                readings_due
);

    localparam logic [15:0] TICKS_RST = 16'd1000;
    localparam logic [15:0] LIMIT_RST = 16'd32767;
    localparam logic [7:0]  WDOG_RST  = 8'd9;

    uemr_pkg::cfg_t  cfg_shadow;
    logic [31:0]     echo_t0;
    logic [15:0]     held_pulse;
    logic [15:0]     window_hist [uemr_pkg::HIST_DEPTH];
    int              hist_wr;
    logic [15:0]     median_ticks;
    bit              update_seen;
    logic [7:0]      idle_count;
    bit              led_lit;
    uemr_pkg::out_t  pending_readings [$];

    function automatic void refresh_median();
        logic [15:0] win [uemr_pkg::MEDIAN_SIZE];
        logic [15:0] v;
        int j;
        for (int i = 0; i < uemr_pkg::HIST_DEPTH; i++) win[i] = window_hist[i];
        win[uemr_pkg::HIST_DEPTH] = held_pulse;
        for (int i = 1; i < uemr_pkg::MEDIAN_SIZE; i++) begin
            v = win[i];
            j = i - 1;
            while (j >= 0 && win[j] > v) begin
                win[j + 1] = win[j];
                j--;
            end
            win[j + 1] = v;
        end
        median_ticks = win[uemr_pkg::MID_IDX];
        window_hist[hist_wr] = held_pulse;
        hist_wr = (hist_wr + 1 == uemr_pkg::HIST_DEPTH) ? 0 : hist_wr + 1;
        update_seen = 1'b1;
    endfunction

    function automatic logic [uemr_pkg::DIST_W-1:0] range_cm(logic [15:0] m);
        logic [63:0] d;
        logic [63:0] q;
        d = (cfg_shadow.ticks_per_ms == 16'd0) ? 64'd1 : 64'(cfg_shadow.ticks_per_ms);
        q = (64'd34 * m + d) / (64'd2 * d);
        return (q > 64'(uemr_pkg::DIST_MAX)) ? uemr_pkg::DIST_MAX : q[uemr_pkg::DIST_W-1:0];
    endfunction

    function automatic uemr_pkg::out_t range_step(uemr_pkg::in_t b);
        uemr_pkg::out_t r;
        logic [31:0] width;
        r = '0;
        if (b.req_type == uemr_tb_pkg::REQ_ECHO) begin
            if (b.echo_level == uemr_tb_pkg::LEVEL_RISE) begin
                echo_t0 = b.timer_count;
                led_lit = 1'b1;
            end else begin
                width = b.timer_count - echo_t0;
                led_lit = 1'b0;
                if (width < 32'(cfg_shadow.pulse_limit))
                    held_pulse = width[15:0];
                else
                    r.sample_rejected = 1'b1;
                refresh_median();
                r.trigger_request = 1'b1;
            end
        end else if (update_seen) begin
            update_seen = 1'b0;
            idle_count = '0;
        end else if (idle_count == cfg_shadow.watchdog_limit) begin
            idle_count = '0;
            refresh_median();
            r.trigger_request = 1'b1;
            r.forced_update = 1'b1;
        end else begin
            idle_count = idle_count + 8'd1;
        end
        r.dist_cm = range_cm(median_ticks);
        r.echo_led = led_lit;
        return r;
    endfunction

    function automatic bit field_ok(string field, longint unsigned want, longint unsigned got,
                                    logic has_x);
        if (has_x || want != got) begin
            $display("%0t: %s expected %0d got %0d%s", $time, field, want, got,
                     has_x ? " (X)" : "");
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit reading_ok(uemr_pkg::out_t want, uemr_pkg::out_t got);
        bit ok;
        ok = field_ok("dist_cm", want.dist_cm, got.dist_cm, $isunknown(got.dist_cm));
        ok &= field_ok("trigger_request", want.trigger_request, got.trigger_request,
                       $isunknown(got.trigger_request));
        ok &= field_ok("echo_led", want.echo_led, got.echo_led, $isunknown(got.echo_led));
        ok &= field_ok("forced_update", want.forced_update, got.forced_update,
                       $isunknown(got.forced_update));
        ok &= field_ok("sample_rejected", want.sample_rejected, got.sample_rejected,
                       $isunknown(got.sample_rejected));
        return ok;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_shadow.ticks_per_ms   = TICKS_RST;
            cfg_shadow.pulse_limit    = LIMIT_RST;
            cfg_shadow.watchdog_limit = WDOG_RST;
            echo_t0      = '0;
            held_pulse   = '0;
            for (int i = 0; i < uemr_pkg::HIST_DEPTH; i++) window_hist[i] = '0;
            hist_wr      = 0;
            median_ticks = '0;
            update_seen  = 1'b0;
            idle_count   = '0;
            led_lit      = 1'b0;
            pending_readings.delete();
            mismatches   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    $display("%0t: unexpected result beat, got %h", $time, m_data);
                    mismatches++;
                end else if (!reading_ok(pending_readings.pop_front(), m_data)) begin
                    mismatches++;
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (uemr_tb_pkg::reg_addr_t'(paddr))
                    uemr_tb_pkg::REG_TICKS_PER_MS:
                        cfg_shadow.ticks_per_ms   = pwdata[15:0];
                    uemr_tb_pkg::REG_PULSE_LIMIT:
                        cfg_shadow.pulse_limit    = pwdata[15:0];
                    uemr_tb_pkg::REG_WATCHDOG_LIMIT:
                        cfg_shadow.watchdog_limit = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pending_readings.push_back(range_step(s_data));
        end
        readings_due = pending_readings.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_BEATS  = 110;
    localparam int PRESSURE_LEN = 300;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    uemr_pkg::in_t   s_data;
    logic            m_valid;
    logic            m_ready;
    uemr_pkg::out_t  m_data;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [3:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    int mismatches;
    int readings_due;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int pressure_rounds = 0;
    int beats_sent = 0;
    logic [15:0] stim_limit = 16'd32767;
    logic [7:0]  stim_wdog = 8'd9;

    ultrasonic_echo_median_ranger u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    uemr_checker u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .readings_due (readings_due)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold whenever the stimulus asks for one
    initial begin
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != pressure_rounds) begin
                holds_done++;
                hold_left = PRESSURE_LEN;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic uemr_pkg::in_t mk_beat(logic req, logic lvl, logic [31:0] t);
        uemr_pkg::in_t b;
        b.req_type    = req;
        b.echo_level  = lvl;
        b.timer_count = t;
        return b;
    endfunction

    // called and returns at a falling edge
    task automatic push_beat(input uemr_pkg::in_t b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic rise(input logic [31:0] t);
        push_beat(mk_beat(uemr_tb_pkg::REQ_ECHO, uemr_tb_pkg::LEVEL_RISE, t));
    endtask

    task automatic fall(input logic [31:0] t);
        push_beat(mk_beat(uemr_tb_pkg::REQ_ECHO, uemr_tb_pkg::LEVEL_FALL, t));
    endtask

    task automatic ticks(input int n);
        repeat (n) push_beat(mk_beat(uemr_tb_pkg::REQ_WATCHDOG, 1'($urandom_range(1)),
                                     $urandom()));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (readings_due != 0) @(negedge aclk);
    endtask

    task automatic apb_write(input uemr_tb_pkg::reg_addr_t a, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a == uemr_tb_pkg::REG_PULSE_LIMIT) stim_limit = v[15:0];
        if (a == uemr_tb_pkg::REG_WATCHDOG_LIMIT) stim_wdog = v[7:0];
    endtask

    task automatic set_config(input logic [15:0] tpm, input logic [15:0] lim,
                              input logic [7:0] wdog);
        apb_write(uemr_tb_pkg::REG_TICKS_PER_MS, {16'($urandom_range(65535)), tpm});
        apb_write(uemr_tb_pkg::REG_PULSE_LIMIT, {16'($urandom_range(65535)), lim});
        apb_write(uemr_tb_pkg::REG_WATCHDOG_LIMIT, {24'($urandom()), wdog});
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
        endcase
    endtask

    // mostly complete echo pulses and watchdog runs, some raw noise
    task automatic run_traffic(input int n);
        int target;
        int pick;
        int burst;
        logic [31:0] start;
        logic [31:0] width;
        target = beats_sent + n;
        while (beats_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                start = $urandom();
                case ($urandom_range(3))
                    0: width = $urandom_range(2000);
                    1: width = 32'(stim_limit) + $urandom_range(3) - 32'd2;
                    2: width = $urandom_range(65535);
                    default: width = $urandom();
                endcase
                rise(start);
                if ($urandom_range(9) == 0) begin
                    start = $urandom();
                    rise(start);
                end
                fall(start + width);
            end else if (pick < 85) begin
                burst = (int'(stim_wdog) + 2 > 20) ? 20 : int'(stim_wdog) + 2;
                ticks($urandom_range(burst, 1));
            end else begin
                push_beat(mk_beat(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom()));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset config, no idling
        fall(32'd100);
        rise(32'hFFFF_FFF0);
        fall(32'h0000_0010);
        rise(32'd5);
        rise(32'd1000);
        fall(32'd1000 + 32'd32766);
        rise(32'd0);
        fall(32'd32767);
        rise(32'hFFFF_FFFF);
        fall(32'hFFFF_FFFF);
        rise(32'h8000_0000);
        fall(32'h0000_0000);
        ticks(12);
        drain();

        set_idling(0);
        set_config(16'd1, 16'd65535, 8'd0);
        pressure_rounds++;
        run_traffic(PHASE_BEATS);
        drain();

        set_idling(1);
        set_config(16'd0, 16'd0, 8'd255);
        run_traffic(PHASE_BEATS);
        drain();

        set_idling(2);
        set_config(16'd65535, 16'd1, 8'd3);
        run_traffic(PHASE_BEATS);
        drain();

        // idle counter left above a lowered limit must wrap before matching
        set_idling(3);
        set_config(16'd1000, 16'd32767, 8'd255);
        ticks(120);
        drain();
        set_config(16'd1000, 16'd32767, 8'd4);
        ticks(150);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            set_idling(ph);
            set_config(16'($urandom_range(2000, 1)), 16'($urandom_range(65535, 1)),
                       8'($urandom_range(12)));
            run_traffic(PHASE_BEATS);
            drain();
        end

        repeat (64) @(negedge aclk);
        if (mismatches == 0 && readings_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
